>>> rtl/core/n2w_pkg.sv
// Shared constants and types for the number-to-word-tokens block.
// No dependencies; used by n2w_front, n2w_queue, n2w_back and the core top level.
package n2w_pkg;

  // Input and output field widths
  localparam int unsigned ValueW = 31;
  localparam int unsigned WordW  = 5;

  // Decimal digits needed for the largest 31-bit value (2147483647)
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BcdW      = 4 * NumDigits;

  // Conversion step counter
  localparam int unsigned StepW = $clog2(ValueW);

  // Digit queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Word token codes
  localparam logic [WordW-1:0] TokZero     = 5'd0;
  localparam logic [WordW-1:0] TokTen      = 5'd10;
  localparam logic [WordW-1:0] TokTwenty   = 5'd20;
  localparam logic [WordW-1:0] TokHundred  = 5'd28;
  localparam logic [WordW-1:0] TokThousand = 5'd29;
  localparam logic [WordW-1:0] TokMillion  = 5'd30;
  localparam logic [WordW-1:0] TokBillion  = 5'd31;

  // Packed decimal digits of one item, least significant digit in bits [3:0]
  typedef logic [BcdW-1:0] bcd_t;

  // Front-to-queue push request
  typedef struct packed {
    logic push;
    bcd_t digits;
  } push_req_t;

endpackage

>>> rtl/core/number_to_word_tokens_core.sv
// Top level: integer to English word tokens.
// Depends on n2w_pkg, n2w_front, n2w_queue and n2w_back.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------
//  input    | start / busy       | value_i[30:0]
//  result   | valid_o (strobe)   | word_o[4:0], last_word_o
//
// An item is taken when start is high and busy is low. The front end
// converts it to decimal digits bit by bit and then hands them to a
// two-entry queue; it takes no new item until that hand-off is done, and
// this converter sets the sustained rate. The back end takes an entry,
// walks five steps for each of four digit groups, then marks the last
// token, and emits 1 to 16 tokens per item. Results cannot be stalled;
// busy stays high while the queue is full. Reset is asynchronous and
// empties both ends and the queue.
module number_to_word_tokens_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic [n2w_pkg::ValueW-1:0]  value_i,
  output logic                        busy,
  output logic                        valid_o,
  output logic [n2w_pkg::WordW-1:0]   word_o,
  output logic                        last_word_o
);

  n2w_pkg::push_req_t  push;
  n2w_pkg::bcd_t       q_data;
  logic                q_full, q_empty, q_pop;

  n2w_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .value_i  (value_i),
    .busy_o   (busy),
    .q_full_i (q_full),
    .push_o   (push)
  );

  n2w_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_data)
  );

  n2w_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_data),
    .pop_o       (q_pop),
    .valid_o     (valid_o),
    .word_o      (word_o),
    .last_word_o (last_word_o)
  );

endmodule

>>> rtl/core/n2w_front.sv
// Front end: accepts an item and converts it to decimal digits by shift-and-add-3.
// Depends on n2w_pkg; feeds n2w_queue.
module n2w_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [n2w_pkg::ValueW-1:0]   value_i,
  output logic                         busy_o,
  input  logic                         q_full_i,
  output n2w_pkg::push_req_t           push_o
);

  typedef enum logic [1:0] {
    FrIdle,
    FrConv,
    FrPush
  } fr_state_e;

  fr_state_e                   state_q, state_d;
  logic [n2w_pkg::StepW-1:0]   cnt_q, cnt_d;
  logic [n2w_pkg::ValueW-1:0]  bin_q, bin_d;
  n2w_pkg::bcd_t               bcd_q, bcd_d;
  n2w_pkg::bcd_t               bcd_adj;

  // Add 3 to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < n2w_pkg::NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // Next-state logic
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    case (state_q)
      FrIdle: begin
        if (start_i) begin
          state_d = FrConv;
          cnt_d   = '0;
          bin_d   = value_i;
          bcd_d   = '0;
        end
      end
      FrConv: begin
        bcd_d = {bcd_adj[n2w_pkg::BcdW-2:0], bin_q[n2w_pkg::ValueW-1]};
        bin_d = {bin_q[n2w_pkg::ValueW-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == n2w_pkg::StepW'(n2w_pkg::ValueW - 1)) begin
          state_d = FrPush;
        end
      end
      FrPush: begin
        if (!q_full_i) begin
          state_d = FrIdle;
        end
      end
      default: begin
        state_d = FrIdle;
      end
    endcase
  end

  // State and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrIdle;
      cnt_q   <= '0;
      bin_q   <= '0;
      bcd_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bin_q   <= bin_d;
      bcd_q   <= bcd_d;
    end
  end

  assign busy_o         = (state_q != FrIdle);
  assign push_o.push    = (state_q == FrPush) && !q_full_i;
  assign push_o.digits  = bcd_q;

  // Checks
  a_start_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == FrConv && cnt_q == '0))
    else $error("front: accepted item did not start conversion");

  a_conv_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FrConv && cnt_q == n2w_pkg::StepW'(n2w_pkg::ValueW - 1)) |=>
    (state_q == FrPush))
    else $error("front: conversion did not finish after the last shift");

  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.push |-> !q_full_i)
    else $error("front: push into a full queue");

endmodule

>>> rtl/core/n2w_queue.sv
// Short digit queue that decouples the converter from the token sequencer.
// Depends on n2w_pkg.
module n2w_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  n2w_pkg::push_req_t   push_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output n2w_pkg::bcd_t        data_o
);

  n2w_pkg::bcd_t               mem_q [n2w_pkg::QDepth];
  logic [n2w_pkg::QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [n2w_pkg::QCntW-1:0]   cnt_q;
  logic                        do_push, do_pop;

  function automatic logic [n2w_pkg::QPtrW-1:0] ptr_inc(input logic [n2w_pkg::QPtrW-1:0] p);
    if (p == n2w_pkg::QPtrW'(n2w_pkg::QDepth - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == n2w_pkg::QCntW'(n2w_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i.push && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.digits;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= n2w_pkg::QCntW'(n2w_pkg::QDepth))
    else $error("queue: fill count out of range");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue: pop from an empty queue");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue: fill count missed a push");

endmodule

>>> rtl/core/n2w_back.sv
// Back end: walks the four digit groups and emits word tokens, at most one per cycle.
// Depends on n2w_pkg; pops digit entries from n2w_queue.
module n2w_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  n2w_pkg::bcd_t               q_data_i,
  output logic                        pop_o,
  output logic                        valid_o,
  output logic [n2w_pkg::WordW-1:0]   word_o,
  output logic                        last_word_o
);

  typedef enum logic [2:0] {
    BkIdle,
    BkHund,
    BkHWord,
    BkTens,
    BkOnes,
    BkScale,
    BkFlush
  } bk_state_e;

  bk_state_e                    state_q;
  n2w_pkg::bcd_t                digits_q;
  logic [1:0]                   group_q;
  logic [n2w_pkg::WordW-1:0]    pend_q;
  logic                         pend_v_q;

  logic [11:0]                  grp;
  logic [3:0]                   hd, td, od;
  logic                         prod;
  logic [n2w_pkg::WordW-1:0]    tok;

  // Select the current three-digit group; the billion group has one digit only
  always_comb begin
    case (group_q)
      2'd0:    grp = {8'b0, digits_q[39:36]};
      2'd1:    grp = digits_q[35:24];
      2'd2:    grp = digits_q[23:12];
      2'd3:    grp = digits_q[11:0];
      default: grp = '0;
    endcase
  end

  assign hd = grp[11:8];
  assign td = grp[7:4];
  assign od = grp[3:0];

  // Token produced in this step, if any
  always_comb begin
    prod = 1'b0;
    tok  = n2w_pkg::TokZero;
    case (state_q)
      BkHund: begin
        prod = (hd != 4'd0);
        tok  = {1'b0, hd};
      end
      BkHWord: begin
        prod = (hd != 4'd0);
        tok  = n2w_pkg::TokHundred;
      end
      BkTens: begin
        if (td >= 4'd2) begin
          prod = 1'b1;
          tok  = n2w_pkg::TokTwenty + {1'b0, td} - 5'd2;
        end else if (td == 4'd1) begin
          // ten to nineteen is one word
          prod = 1'b1;
          tok  = n2w_pkg::TokTen + {1'b0, od};
        end else begin
          prod = (od != 4'd0);
          tok  = {1'b0, od};
        end
      end
      BkOnes: begin
        prod = (td >= 4'd2) && (od != 4'd0);
        tok  = {1'b0, od};
      end
      BkScale: begin
        prod = (grp != '0) && (group_q != 2'd3);
        tok  = n2w_pkg::TokBillion - {3'b0, group_q};
      end
      default: begin
        prod = 1'b0;
        tok  = n2w_pkg::TokZero;
      end
    endcase
  end

  assign pop_o = (state_q == BkIdle) && !q_empty_i;

  // Sequencer; each token is held in a pending register so the final one can be marked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      digits_q    <= '0;
      group_q     <= '0;
      pend_q      <= '0;
      pend_v_q    <= 1'b0;
      valid_o     <= 1'b0;
      word_o      <= '0;
      last_word_o <= 1'b0;
    end else begin
      valid_o     <= 1'b0;
      last_word_o <= 1'b0;
      if (prod) begin
        if (pend_v_q) begin
          valid_o <= 1'b1;
          word_o  <= pend_q;
        end
        pend_q   <= tok;
        pend_v_q <= 1'b1;
      end
      case (state_q)
        BkIdle: begin
          if (!q_empty_i) begin
            digits_q <= q_data_i;
            group_q  <= '0;
            pend_v_q <= 1'b0;
            state_q  <= BkHund;
          end
        end
        BkHund:  state_q <= BkHWord;
        BkHWord: state_q <= BkTens;
        BkTens:  state_q <= BkOnes;
        BkOnes:  state_q <= BkScale;
        BkScale: begin
          if (group_q == 2'd3) begin
            state_q <= BkFlush;
          end else begin
            group_q <= group_q + 2'd1;
            state_q <= BkHund;
          end
        end
        BkFlush: begin
          // a zero input leaves nothing pending and speaks Zero
          valid_o     <= 1'b1;
          last_word_o <= 1'b1;
          word_o      <= pend_v_q ? pend_q : n2w_pkg::TokZero;
          pend_v_q    <= 1'b0;
          state_q     <= BkIdle;
        end
        default: begin
          state_q <= BkIdle;
        end
      endcase
    end
  end

  // Checks
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_word_o) |=> !valid_o)
    else $error("back: token directly after the final token of an item");

  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkFlush) |=> (valid_o && last_word_o && state_q == BkIdle))
    else $error("back: flush did not emit the final token");

  a_last_only_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_word_o |-> ($past(state_q) == BkFlush))
    else $error("back: final-token mark outside flush");

endmodule

>>> test/number_to_word_tokens_checker.sv
`timescale 1ns / 1ps
// Result checker for number_to_word_tokens_core: spells every accepted number
// into expected word tokens and compares each strobed result. Uses n2w_pkg.
module number_to_word_tokens_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic [n2w_pkg::ValueW-1:0] value_i,
  input  logic                       valid_i,
  input  logic [n2w_pkg::WordW-1:0]  word_i,
  input  logic                       last_word_i,
  output int unsigned                mismatch_cnt_o,
  output int unsigned                pending_o,
  output int unsigned                number_cnt_o,
  output int unsigned                token_cnt_o,
  output int unsigned                longest_run_o
);

  typedef logic [n2w_pkg::WordW-1:0] word_t;

  typedef struct packed {
    word_t word;
    logic  last;
  } token_t;

  token_t      spoken_q[$];
  int unsigned run_len;

  assign pending_o = spoken_q.size();

  task automatic say(input word_t w);
    spoken_q.push_back('{word: w, last: 1'b0});
  endtask

  // Words for one nonzero three-digit group, scale word excluded
  task automatic spell_group(input int unsigned grp);
    int unsigned hund;
    int unsigned rest;
    hund = grp / 100;
    rest = grp % 100;
    if (hund != 0) begin
      say(n2w_pkg::TokZero + word_t'(hund));
      say(n2w_pkg::TokHundred);
    end
    if (rest != 0 && rest < 20) begin
      say(n2w_pkg::TokZero + word_t'(rest));
    end else if (rest != 0) begin
      say(n2w_pkg::TokTwenty + word_t'(rest / 10 - 2));
      if (rest % 10 != 0) say(n2w_pkg::TokZero + word_t'(rest % 10));
    end
  endtask

  // Expected token run for one number; zero groups say nothing at all
  task automatic spell_number(input logic [n2w_pkg::ValueW-1:0] value);
    int unsigned v;
    int unsigned billions;
    int unsigned millions;
    int unsigned thousands;
    int unsigned units;
    v         = int'(value);
    billions  = v / 1000000000;
    millions  = (v / 1000000) % 1000;
    thousands = (v / 1000) % 1000;
    units     = v % 1000;
    if (v == 0) begin
      spoken_q.push_back('{word: n2w_pkg::TokZero, last: 1'b1});
    end else begin
      if (billions != 0) begin
        spell_group(billions);
        say(n2w_pkg::TokBillion);
      end
      if (millions != 0) begin
        spell_group(millions);
        say(n2w_pkg::TokMillion);
      end
      if (thousands != 0) begin
        spell_group(thousands);
        say(n2w_pkg::TokThousand);
      end
      if (units != 0) spell_group(units);
      spoken_q[spoken_q.size()-1].last = 1'b1;
    end
  endtask

  task automatic flag(input string what, input token_t exp_tok, input token_t got_tok);
    mismatch_cnt_o++;
    if (mismatch_cnt_o <= 10)
      $display("%0t: %s: expected word %0d last %0b, got word %0d last %0b", $realtime,
               what, exp_tok.word, exp_tok.last, got_tok.word, got_tok.last);
  endtask

  initial begin
    mismatch_cnt_o = 0;
    number_cnt_o   = 0;
    token_cnt_o    = 0;
    longest_run_o  = 0;
    run_len        = 0;
  end

  // Values sampled at the edge are those of the cycle just ending
  always @(posedge clk_i) begin
    token_t got_tok;
    token_t exp_tok;
    if (rst_ni) begin
      if (valid_i) begin
        got_tok = '{word: word_i, last: last_word_i};
        token_cnt_o++;
        run_len++;
        if (run_len > longest_run_o) longest_run_o = run_len;
        if (last_word_i) run_len = 0;
        if (spoken_q.size() == 0) begin
          flag("unexpected token", '0, got_tok);
        end else begin
          exp_tok = spoken_q.pop_front();
          if (exp_tok.word !== got_tok.word) flag("word mismatch", exp_tok, got_tok);
          else if (exp_tok.last !== got_tok.last) flag("last_word mismatch", exp_tok, got_tok);
        end
      end
      // New item after the result check, so a token never meets its own item
      if (start_i && !busy_i) begin
        number_cnt_o++;
        spell_number(value_i);
      end
    end
  end

endmodule

>>> test/number_to_word_tokens_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for number_to_word_tokens_core: drives directed and random
// numbers and gives the verdict. Depends on n2w_pkg and the token checker.
module number_to_word_tokens_core_tb;

  localparam int unsigned RandomItems = 340;
  localparam int unsigned SteadyItems = 40;   // tail of the run without gaps
  localparam int unsigned DrainCycles = 80;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic [n2w_pkg::ValueW-1:0] value_i;
  logic                       busy;
  logic                       valid_o;
  logic [n2w_pkg::WordW-1:0]  word_o;
  logic                       last_word_o;

  int unsigned mismatch_cnt;
  int unsigned pending;
  int unsigned number_cnt;
  int unsigned token_cnt;
  int unsigned longest_run;

  number_to_word_tokens_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .value_i     (value_i),
    .busy        (busy),
    .valid_o     (valid_o),
    .word_o      (word_o),
    .last_word_o (last_word_o)
  );

  number_to_word_tokens_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .value_i        (value_i),
    .valid_i        (valid_o),
    .word_i         (word_o),
    .last_word_i    (last_word_o),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending),
    .number_cnt_o   (number_cnt),
    .token_cnt_o    (token_cnt),
    .longest_run_o  (longest_run)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Offer one number and hold it until taken; start stays high afterwards
  task automatic offer(input logic [n2w_pkg::ValueW-1:0] v);
    start   <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic pause(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Hold off until every token spoken for has come out
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // One three-digit group, biased towards zero, round and teen shapes
  function automatic int unsigned pick_group();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return $urandom_range(1, 9) * 100;
      2:       return $urandom_range(0, 9) * 100 + $urandom_range(2, 9) * 10;
      3:       return $urandom_range(0, 9) * 100 + $urandom_range(10, 19);
      default: return $urandom_range(1, 999);
    endcase
  endfunction

  function automatic logic [n2w_pkg::ValueW-1:0] pick_value();
    int unsigned billions;
    int unsigned millions;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: return n2w_pkg::ValueW'($urandom());
      6, 7:             return n2w_pkg::ValueW'($urandom_range(0, 999));
      8:                return n2w_pkg::ValueW'($urandom_range(0, 99));
      9:                return {n2w_pkg::ValueW{1'b1}};
      default: begin
        billions = $urandom_range(0, 2);
        millions = (billions == 2) ? $urandom_range(0, 146) : pick_group();
        return n2w_pkg::ValueW'(billions * 1000000000 + millions * 1000000
                                + pick_group() * 1000 + pick_group());
      end
    endcase
  endfunction

  initial begin
    int unsigned directed[$];
    start   <= 1'b0;
    value_i <= '0;
    rst_ni  <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero, teens, round tens and hundreds, zero groups, longest run, all ones
    directed = '{0, 1, 9, 10, 13, 19, 20, 21, 90, 99, 100, 101, 115, 700, 999,
                 1000, 1000000, 1000000000, 2000000005, 1000010000, 1777777777,
                 1234567890, 2147483647, 1073741824};
    foreach (directed[i]) begin
      offer(n2w_pkg::ValueW'(directed[i]));
      if ($urandom_range(0, 2) == 0) pause($urandom_range(1, 13));
    end
    drain();

    for (int unsigned n = 0; n < RandomItems; n++) begin
      offer(pick_value());
      if (n == RandomItems / 2) drain();
      else if (n < RandomItems - SteadyItems && $urandom_range(0, 3) == 0)
        pause($urandom_range(1, 13));
    end
    start <= 1'b0;

    drain();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Spelled %0d numbers into %0d word tokens, longest run %0d tokens.",
             number_cnt, token_cnt, longest_run);
    $display("Covered zero, teens, round tens and hundreds, empty groups and all scales.");
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run
  initial begin
    #5ms;
    $display("Timeout with %0d tokens still awaited", pending);
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/n2w_pkg.sv
rtl/core/n2w_front.sv
rtl/core/n2w_queue.sv
rtl/core/n2w_back.sv
rtl/core/number_to_word_tokens_core.sv
test/number_to_word_tokens_checker.sv
test/number_to_word_tokens_core_tb.sv
